@@ src/assert_macros.svh @@
// Assertion macros used by the texture animation sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define TAS_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define TAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the following cycle.
`define TAS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tas_pkg.sv @@
// ----------------------------------------------------------------------------
// tas_pkg
// Types, codes and defaults shared by the texture animation sequencer.
// ----------------------------------------------------------------------------
package tas_pkg;

   localparam int unsigned DEF_MAX_ANIMS  = 16;
   localparam int unsigned DEF_MAX_FRAMES = 32;
   localparam int unsigned TIME_W         = 32;
   localparam int unsigned PIC_W          = 16;
   localparam logic [TIME_W-1:0] LFSR_MASK = 32'h8020_0003;

   typedef enum logic [1:0] {
      CMD_DEFINE = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_TABLE_FULL = 3'd1,
      STS_STORE_FULL = 3'd2,
      STS_NO_OPEN    = 3'd3,
      STS_EMPTY      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      MODE_FORWARD   = 3'd0,
      MODE_BACKWARD  = 3'd1,
      MODE_OSC_UP    = 3'd2,
      MODE_OSC_DOWN  = 3'd3,
      MODE_DISCRETE  = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DEF_WR,
      ST_ENT_RD,
      ST_APP_CHK,
      ST_TICK_EVAL,
      ST_FS_RD,
      ST_FS_CAP,
      ST_MOD_WAIT,
      ST_ENT_WB,
      ST_EMIT_PREP,
      ST_PIC_RD,
      ST_PIC_CAP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] speed_min;
      logic [TIME_W-1:0] speed_range;
      logic [PIC_W-1:0]  pic;
   } frame_entry_type;

endpackage

@@ src/tas_mod_unit.sv @@
// ----------------------------------------------------------------------------
// tas_mod_unit
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tas_mod_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tas_pkg::TIME_W-1:0] dividend,
   input  logic [tas_pkg::TIME_W-1:0] divisor,
   output logic                      done,
   output logic [tas_pkg::TIME_W-1:0] remainder
);
   import tas_pkg::*;

   localparam int unsigned CNT_W = $clog2(TIME_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [TIME_W-1:0] div_ff, div_in;
   logic [TIME_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      trial   = {rem_ff, dvd_ff[TIME_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TIME_W);
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = TIME_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[TIME_W-1:0];
         end
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ src/texture_animation_sequencer.sv @@
// ----------------------------------------------------------------------------
// texture_animation_sequencer
// Animation table and frame store stepped on time ticks.
// ----------------------------------------------------------------------------
//  port group | direction | meaning
//  req_*      | in        | command word: define, append frame, tick
//  rsp_*      | out       | one result word per animation reported
//  csr_*      | in        | jitter generator seed
//
// A define searches the used table entries one by one before it writes, and an
// append reads the open entry, checks it and writes it back. A tick steps through
// every entry, fetches a discrete frame's picture, and when the entry is due reads
// its frame timing and may draw jitter through the one-bit-per-cycle remainder
// unit. The sequencer returns to its idle state before the next command is taken.
// Reset is synchronous and needs no clearing pass; a stalled result word holds
// the sequencer in its emit state.
`include "assert_macros.svh"

module texture_animation_sequencer #(
   parameter int unsigned MAX_ANIMS  = tas_pkg::DEF_MAX_ANIMS,
   parameter int unsigned MAX_FRAMES = tas_pkg::DEF_MAX_FRAMES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_pic,
   input  logic [5:0]  req_frame_count,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_speed_min,
   input  logic [31:0] req_speed_range,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_base_pic,
   output logic [15:0] rsp_shown_pic,
   output logic [4:0]  rsp_current_frame,
   output logic [5:0]  rsp_frame_total,
   output logic        rsp_is_discrete,
   output logic        rsp_last
);
   import tas_pkg::*;

   localparam int unsigned SW = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
   localparam int unsigned UW = $clog2(MAX_ANIMS + 1);
   localparam int unsigned FW = $clog2(MAX_FRAMES);
   localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
   localparam int unsigned FS_DEPTH = MAX_ANIMS * MAX_FRAMES;
   localparam int unsigned AW = (FS_DEPTH > 1) ? $clog2(FS_DEPTH) : 1;

   typedef struct packed {
      logic [PIC_W-1:0]  base;
      logic [CW-1:0]     frames;
      mode_type          mode;
      logic [FW-1:0]     cur;
      logic [TIME_W-1:0] switch_at;
   } anim_entry_type;

   // Memories.
   anim_entry_type  anim_mem [MAX_ANIMS];
   frame_entry_type fs_mem   [FS_DEPTH];

   logic            anim_we;
   logic [SW-1:0]   anim_waddr, anim_raddr;
   anim_entry_type  anim_wdata, anim_rdata;
   logic            fs_we;
   logic [AW-1:0]   fs_waddr, fs_raddr;
   frame_entry_type fs_wdata, fs_rdata;

   // Control state.
   state_type         state_ff, state_in;
   logic [UW-1:0]     used_ff;
   logic              open_valid_ff;
   logic [SW-1:0]     open_slot_ff;
   logic [TIME_W-1:0] lfsr_ff, lfsr_next;
   logic              rsp_valid_ff;

   // Working registers.
   cmd_type           cmd_ff;
   logic [PIC_W-1:0]  pic_ff;
   logic [5:0]        cnt_ff;
   logic [2:0]        mode_ff;
   logic [TIME_W-1:0] smin_ff, srng_ff, now_ff;
   logic [SW-1:0]     slot_ff, idx_ff;
   anim_entry_type    ent_ff;
   logic [PIC_W-1:0]  shown_ff;
   status_type        status_ff;
   logic [TIME_W-1:0] t_ff;

   // Output register.
   logic [2:0]        rsp_status_ff;
   logic [15:0]       rsp_base_ff, rsp_shown_ff;
   logic [4:0]        rsp_cur_ff;
   logic [5:0]        rsp_total_ff;
   logic              rsp_disc_ff, rsp_last_ff;

   // Combinational helpers.
   logic              out_free, last_w, more_w, match_w, srch_end_w, full_w;
   logic              due_w, store_full_w, pic_read_w;
   mode_type          def_mode;
   logic [CW-1:0]     def_frames;
   anim_entry_type    def_entry, adv_entry, app_entry;
   logic [CW-1:0]     n_m1, c_inc;
   logic [FW-1:0]     c_dec;
   logic              mod_start, mod_done;
   logic [TIME_W-1:0] mod_rem;
   logic [31:0]       cnt_wide;

   function automatic logic [AW-1:0] fs_addr(input logic [SW-1:0] s,
                                             input logic [FW-1:0] f);
      return AW'(32'(s) * 32'(MAX_FRAMES) + 32'(f));
   endfunction

   tas_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (lfsr_next),
      .divisor   (fs_rdata.speed_range),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (anim_we) begin
         anim_mem[anim_waddr] <= anim_wdata;
      end
      anim_rdata <= anim_mem[anim_raddr];
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= fs_wdata;
      end
      fs_rdata <= fs_mem[fs_raddr];
   end

   // Galois step of the jitter generator.
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_MASK) : (lfsr_ff >> 1);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_w     = (cmd_ff != CMD_TICK) || (used_ff == '0)
                       || (UW'(slot_ff) + UW'(1) == used_ff);
   assign more_w     = (cmd_ff == CMD_TICK) && !last_w;
   assign match_w    = (anim_rdata.base == pic_ff);
   assign srch_end_w = (UW'(idx_ff) + UW'(1) == used_ff);
   assign full_w     = (32'(used_ff) >= 32'(MAX_ANIMS));
   assign store_full_w = (32'(anim_rdata.frames) >= 32'(MAX_FRAMES));
   assign due_w      = (anim_rdata.frames != '0)
                       && ((anim_rdata.switch_at == '0) || (anim_rdata.switch_at <= now_ff));
   assign pic_read_w = (ent_ff.mode == MODE_DISCRETE) && (ent_ff.frames != '0);

   // Entry written by a define.
   always_comb begin
      cnt_wide = 32'(cnt_ff);
      if (mode_ff > 3'(MODE_DISCRETE)) begin
         def_mode = MODE_FORWARD;
      end else begin
         def_mode = mode_type'(mode_ff);
      end
      if (cnt_wide < 32'd2) begin
         def_frames = CW'(2);
      end else if (cnt_wide > 32'(MAX_FRAMES)) begin
         def_frames = CW'(MAX_FRAMES);
      end else begin
         def_frames = CW'(cnt_wide);
      end
      def_entry.base      = pic_ff;
      def_entry.frames    = (def_mode == MODE_DISCRETE) ? '0 : def_frames;
      def_entry.mode      = def_mode;
      def_entry.cur       = '0;
      def_entry.switch_at = '0;
   end

   // Entry after one append.
   always_comb begin
      app_entry        = anim_rdata;
      app_entry.frames = anim_rdata.frames + CW'(1);
   end

   // Entry after one frame step, taken only when the entry is due and already timed.
   always_comb begin
      adv_entry = anim_rdata;
      n_m1  = anim_rdata.frames - CW'(1);
      c_inc = CW'(anim_rdata.cur) + CW'(1);
      c_dec = (anim_rdata.cur == '0) ? FW'(n_m1) : anim_rdata.cur - FW'(1);
      if (due_w && (anim_rdata.switch_at != '0)) begin
         case (anim_rdata.mode)
            MODE_BACKWARD: begin
               adv_entry.cur = c_dec;
            end
            MODE_OSC_UP: begin
               adv_entry.cur = FW'(c_inc);
               if (c_inc >= n_m1) begin
                  adv_entry.mode = MODE_OSC_DOWN;
               end
            end
            MODE_OSC_DOWN: begin
               adv_entry.cur = c_dec;
               if (c_dec == '0) begin
                  adv_entry.mode = MODE_OSC_UP;
               end
            end
            default: begin
               adv_entry.cur = (c_inc >= anim_rdata.frames) ? '0 : FW'(c_inc);
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (cmd_type'(req_command))
                  CMD_DEFINE: state_in = (used_ff == '0) ? ST_DEF_WR : ST_SRCH_RD;
                  CMD_APPEND: state_in = open_valid_ff ? ST_ENT_RD : ST_EMIT;
                  CMD_TICK:   state_in = (used_ff == '0) ? ST_EMIT : ST_ENT_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SRCH_RD:  state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (match_w) begin
               state_in = ST_DEF_WR;
            end else if (srch_end_w) begin
               state_in = full_w ? ST_EMIT : ST_DEF_WR;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_DEF_WR:    state_in = ST_EMIT;
         ST_ENT_RD:    state_in = (cmd_ff == CMD_APPEND) ? ST_APP_CHK : ST_TICK_EVAL;
         ST_APP_CHK:   state_in = ST_EMIT_PREP;
         ST_TICK_EVAL: state_in = due_w ? ST_FS_RD : ST_EMIT_PREP;
         ST_FS_RD:     state_in = ST_FS_CAP;
         ST_FS_CAP:    state_in = (fs_rdata.speed_range != '0) ? ST_MOD_WAIT : ST_ENT_WB;
         ST_MOD_WAIT:  state_in = mod_done ? ST_ENT_WB : ST_MOD_WAIT;
         ST_ENT_WB:    state_in = ST_EMIT_PREP;
         ST_EMIT_PREP: state_in = pic_read_w ? ST_PIC_RD : ST_EMIT;
         ST_PIC_RD:    state_in = ST_PIC_CAP;
         ST_PIC_CAP:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = more_w ? ST_ENT_RD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory and unit controls.
   always_comb begin
      anim_we    = 1'b0;
      anim_waddr = slot_ff;
      anim_wdata = ent_ff;
      anim_raddr = (state_ff == ST_SRCH_RD) ? idx_ff : slot_ff;
      fs_we      = 1'b0;
      fs_waddr   = fs_addr(slot_ff, '0);
      fs_wdata   = '{speed_min: smin_ff, speed_range: srng_ff, pic: pic_ff};
      fs_raddr   = fs_addr(slot_ff, ent_ff.cur);
      mod_start  = 1'b0;
      unique case (state_ff)
         ST_DEF_WR: begin
            anim_we    = 1'b1;
            anim_wdata = def_entry;
            fs_we      = (def_mode != MODE_DISCRETE);
         end
         ST_APP_CHK: begin
            anim_we    = !store_full_w;
            anim_wdata = app_entry;
            fs_we      = !store_full_w;
            fs_waddr   = fs_addr(slot_ff, FW'(anim_rdata.frames));
         end
         ST_FS_RD: begin
            fs_raddr = fs_addr(slot_ff, (ent_ff.mode == MODE_DISCRETE) ? ent_ff.cur : '0);
         end
         ST_FS_CAP: begin
            mod_start = (fs_rdata.speed_range != '0);
         end
         ST_ENT_WB: begin
            anim_we              = 1'b1;
            anim_wdata.switch_at = t_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         open_valid_ff <= 1'b0;
         open_slot_ff  <= '0;
         lfsr_ff       <= 32'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && req_valid && cmd_type'(req_command) == CMD_DEFINE) begin
            open_valid_ff <= 1'b0;
            if (used_ff == '0) begin
               used_ff <= UW'(1);
            end
         end
         if (state_ff == ST_SRCH_CMP && !match_w && srch_end_w && !full_w) begin
            used_ff <= used_ff + UW'(1);
         end
         if (state_ff == ST_DEF_WR && def_mode == MODE_DISCRETE) begin
            open_valid_ff <= 1'b1;
            open_slot_ff  <= slot_ff;
         end
         if (csr_wr_en) begin
            lfsr_ff <= (csr_wr_data == '0) ? 32'd1 : csr_wr_data;
         end else if (mod_start) begin
            lfsr_ff <= lfsr_next;
         end
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and output registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff    <= cmd_type'(req_command);
            pic_ff    <= req_pic;
            cnt_ff    <= req_frame_count;
            mode_ff   <= req_mode;
            smin_ff   <= req_speed_min;
            srng_ff   <= req_speed_range;
            now_ff    <= req_now_ms;
            idx_ff    <= '0;
            slot_ff   <= (cmd_type'(req_command) == CMD_APPEND) ? open_slot_ff : '0;
            ent_ff    <= '0;
            shown_ff  <= '0;
            status_ff <= (cmd_type'(req_command) == CMD_APPEND) ? STS_NO_OPEN : STS_EMPTY;
         end
         ST_SRCH_CMP: begin
            if (match_w) begin
               slot_ff <= idx_ff;
            end else if (srch_end_w) begin
               // The working entry is still clear from the idle state.
               slot_ff     <= SW'(used_ff);
               ent_ff.base <= pic_ff;
               status_ff   <= STS_TABLE_FULL;
            end else begin
               idx_ff <= idx_ff + SW'(1);
            end
         end
         ST_DEF_WR: begin
            ent_ff    <= def_entry;
            shown_ff  <= pic_ff;
            status_ff <= STS_OK;
         end
         ST_APP_CHK: begin
            ent_ff    <= store_full_w ? anim_rdata : app_entry;
            status_ff <= store_full_w ? STS_STORE_FULL : STS_OK;
         end
         ST_TICK_EVAL: begin
            ent_ff    <= adv_entry;
            status_ff <= STS_OK;
         end
         ST_FS_CAP: begin
            t_ff <= now_ff + fs_rdata.speed_min;
         end
         ST_MOD_WAIT: begin
            if (mod_done) begin
               t_ff <= t_ff + mod_rem;
            end
         end
         ST_ENT_WB: begin
            ent_ff.switch_at <= t_ff;
         end
         ST_EMIT_PREP: begin
            shown_ff <= ent_ff.base + PIC_W'(ent_ff.cur);
         end
         ST_PIC_CAP: begin
            shown_ff <= fs_rdata.pic;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_status_ff <= status_ff;
               rsp_base_ff   <= ent_ff.base;
               rsp_shown_ff  <= shown_ff;
               rsp_cur_ff    <= 5'(ent_ff.cur);
               rsp_total_ff  <= 6'(ent_ff.frames);
               rsp_disc_ff   <= (ent_ff.mode == MODE_DISCRETE);
               rsp_last_ff   <= last_w;
               if (more_w) begin
                  slot_ff <= slot_ff + SW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_base_pic      = rsp_base_ff;
   assign rsp_shown_pic     = rsp_shown_ff;
   assign rsp_current_frame = rsp_cur_ff;
   assign rsp_frame_total   = rsp_total_ff;
   assign rsp_is_discrete   = rsp_disc_ff;
   assign rsp_last          = rsp_last_ff;

   `TAS_ASSERT(a_used_bound, clock, reset, 32'(used_ff) <= 32'(MAX_ANIMS), "table count overflow")
   `TAS_ASSERT_IMP(a_open_in_table, clock, reset, open_valid_ff, UW'(open_slot_ff) < used_ff, "open slot outside table")
   `TAS_ASSERT(a_lfsr_live, clock, reset, lfsr_ff != '0, "jitter generator locked at zero")
   `TAS_ASSERT_NXT(a_emit_held, clock, reset, state_ff == ST_EMIT && rsp_valid_ff && rsp_stall, state_ff == ST_EMIT, "result word lost under stall")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives define, append, tick and ignored words into the texture animation sequencer
// with random gaps on both sides, predicts every result word from its own
// animation table, frame store and jitter generator, and compares them.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tas_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 80;
   localparam int TABLE_DEPTH    = 16;
   localparam int FRAME_DEPTH    = 32;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] base_pic;
      logic [15:0] shown_pic;
      logic [4:0]  current_frame;
      logic [5:0]  frame_total;
      logic        is_discrete;
      logic        last;
   } anim_report_type;

   class anim_scoreboard_type;
      logic [15:0] base[TABLE_DEPTH];
      int          frames[TABLE_DEPTH];
      int          mode[TABLE_DEPTH];
      int          cur[TABLE_DEPTH];
      logic [31:0] switch_at[TABLE_DEPTH];
      logic [31:0] f_min[TABLE_DEPTH*FRAME_DEPTH];
      logic [31:0] f_range[TABLE_DEPTH*FRAME_DEPTH];
      logic [15:0] f_pic[TABLE_DEPTH*FRAME_DEPTH];
      int          used;
      int          open_slot;
      logic [31:0] jitter;
      anim_report_type expected_reports[$];
      int          mismatches;

      function new();
         used = 0;
         open_slot = -1;
         jitter = 32'd1;
         mismatches = 0;
      endfunction

      function void load_seed(logic [31:0] seed);
         jitter = (seed == 0) ? 32'd1 : seed;
      endfunction

      function logic [31:0] draw_jitter();
         logic lsb;
         lsb = jitter[0];
         jitter = jitter >> 1;
         if (lsb) begin
            jitter = jitter ^ LFSR_MASK;
         end
         return jitter;
      endfunction

      function void retime(int s, logic [31:0] now);
         int idx;
         logic [31:0] t;
         idx = s * FRAME_DEPTH + ((mode[s] == MODE_DISCRETE) ? cur[s] : 0);
         t = now + f_min[idx];
         if (f_range[idx] != 0) begin
            t = t + (draw_jitter() % f_range[idx]);
         end
         switch_at[s] = t;
      endfunction

      function void step_frame(int s);
         int n;
         int c;
         n = frames[s];
         c = cur[s];
         case (mode[s])
            MODE_BACKWARD: c = (c == 0) ? n - 1 : c - 1;
            MODE_OSC_UP: begin
               c = c + 1;
               if (c >= n - 1) mode[s] = MODE_OSC_DOWN;
            end
            MODE_OSC_DOWN: begin
               c = (c == 0) ? n - 1 : c - 1;
               if (c == 0) mode[s] = MODE_OSC_UP;
            end
            default: c = (c + 1) % n;
         endcase
         cur[s] = c;
      endfunction

      function void push_entry(status_type st, int s, logic last);
         anim_report_type r;
         r.status = st;
         r.base_pic = base[s];
         if (mode[s] == MODE_DISCRETE) begin
            r.shown_pic = (frames[s] != 0) ? f_pic[s*FRAME_DEPTH + cur[s]] : base[s];
         end else begin
            r.shown_pic = base[s] + 16'(cur[s]);
         end
         r.current_frame = 5'(cur[s]);
         r.frame_total = 6'(frames[s]);
         r.is_discrete = (mode[s] == MODE_DISCRETE);
         r.last = last;
         expected_reports.push_back(r);
      endfunction

      function void push_blank(status_type st, logic [15:0] b);
         anim_report_type r;
         r = '{st, b, 16'd0, 5'd0, 6'd0, 1'b0, 1'b1};
         expected_reports.push_back(r);
      endfunction

      function void note_word(logic [1:0] cmd, logic [15:0] pic, logic [5:0] cnt,
                              logic [2:0] md, logic [31:0] smin, logic [31:0] srng,
                              logic [31:0] now);
         int s;
         int idx;
         int m;
         int n;
         case (cmd)
            CMD_DEFINE: begin
               open_slot = -1;
               for (s = 0; s < used; s++) begin
                  if (base[s] == pic) break;
               end
               if (s == used) begin
                  if (used >= TABLE_DEPTH) begin
                     push_blank(STS_TABLE_FULL, pic);
                     return;
                  end
                  used++;
               end
               m = (md > MODE_DISCRETE) ? MODE_FORWARD : md;
               base[s] = pic;
               mode[s] = m;
               cur[s] = 0;
               switch_at[s] = 0;
               if (m == MODE_DISCRETE) begin
                  frames[s] = 0;
                  open_slot = s;
               end else begin
                  n = cnt;
                  if (n < 2) n = 2;
                  if (n > FRAME_DEPTH) n = FRAME_DEPTH;
                  frames[s] = n;
                  f_min[s*FRAME_DEPTH] = smin;
                  f_range[s*FRAME_DEPTH] = srng;
                  f_pic[s*FRAME_DEPTH] = pic;
               end
               push_entry(STS_OK, s, 1'b1);
            end
            CMD_APPEND: begin
               if (open_slot < 0 || open_slot >= used) begin
                  push_blank(STS_NO_OPEN, 16'd0);
               end else if (frames[open_slot] >= FRAME_DEPTH) begin
                  push_entry(STS_STORE_FULL, open_slot, 1'b1);
               end else begin
                  s = open_slot;
                  idx = s * FRAME_DEPTH + frames[s];
                  f_min[idx] = smin;
                  f_range[idx] = srng;
                  f_pic[idx] = pic;
                  frames[s]++;
                  push_entry(STS_OK, s, 1'b1);
               end
            end
            CMD_TICK: begin
               if (used == 0) begin
                  push_blank(STS_EMPTY, 16'd0);
                  return;
               end
               for (s = 0; s < used; s++) begin
                  if (frames[s] != 0) begin
                     if (switch_at[s] == 0) begin
                        retime(s, now);
                     end else if (switch_at[s] <= now) begin
                        step_frame(s);
                        retime(s, now);
                     end
                  end
                  push_entry(STS_OK, s, s + 1 == used);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(anim_report_type got);
         anim_report_type e;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result word with nothing expected: st=%0d base=%h",
                        $time, got.status, got.base_pic);
            end
            return;
         end
         e = expected_reports.pop_front();
         if (got.status !== e.status || got.base_pic !== e.base_pic ||
             got.shown_pic !== e.shown_pic || got.current_frame !== e.current_frame ||
             got.frame_total !== e.frame_total || got.is_discrete !== e.is_discrete ||
             got.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: expected st=%0d base=%h shown=%h cur=%0d tot=%0d disc=%b last=%b",
                        $time, e.status, e.base_pic, e.shown_pic, e.current_frame,
                        e.frame_total, e.is_discrete, e.last);
               $display("%0t:   actual st=%0d base=%h shown=%h cur=%0d tot=%0d disc=%b last=%b",
                        $time, got.status, got.base_pic, got.shown_pic, got.current_frame,
                        got.frame_total, got.is_discrete, got.last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_NONE;
   logic [15:0] req_pic = '0;
   logic [5:0]  req_frame_count = '0;
   logic [2:0]  req_mode = '0;
   logic [31:0] req_speed_min = '0;
   logic [31:0] req_speed_range = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_base_pic;
   logic [15:0] rsp_shown_pic;
   logic [4:0]  rsp_current_frame;
   logic [5:0]  rsp_frame_total;
   logic        rsp_is_discrete;
   logic        rsp_last;

   anim_scoreboard_type sb = new();
   bit          gaps_on = 1'b1;
   int          quiet_cycles = 0;
   logic [31:0] clock_ms = 0;

   texture_animation_sequencer dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_pic(req_pic), .req_frame_count(req_frame_count), .req_mode(req_mode),
      .req_speed_min(req_speed_min), .req_speed_range(req_speed_range),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_base_pic(rsp_base_pic), .rsp_shown_pic(rsp_shown_pic),
      .rsp_current_frame(rsp_current_frame), .rsp_frame_total(rsp_frame_total),
      .rsp_is_discrete(rsp_is_discrete), .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: check the word taken at this edge, then choose the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word('{rsp_status, rsp_base_pic, rsp_shown_pic, rsp_current_frame,
                         rsp_frame_total, rsp_is_discrete, rsp_last});
      end
      rsp_stall <= gaps_on && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [15:0] pic, logic [5:0] cnt,
                            logic [2:0] md, logic [31:0] smin, logic [31:0] srng,
                            logic [31:0] now);
      if (gaps_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (gaps_on && $urandom_range(99) < 13) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pic <= pic;
      req_frame_count <= cnt;
      req_mode <= md;
      req_speed_min <= smin;
      req_speed_range <= srng;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(cmd, pic, cnt, md, smin, srng, now);
   endtask

   task automatic tick_at(logic [31:0] now);
      send_word(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, now);
   endtask

   // Wait until every result has come, plus time for an ignored word to drain, then load the seed.
   task automatic drain_and_seed(logic [31:0] seed);
      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.load_seed(seed);
   endtask

   function automatic logic [15:0] pick_pic();
      return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(19) * 37);
   endfunction

   function automatic logic [31:0] pick_span();
      return ($urandom_range(15) == 0) ? $urandom : $urandom_range(8);
   endfunction

   task automatic random_phase(int count);
      int done;
      int k;
      int n;
      logic [2:0] md;
      done = 0;
      while (done < count) begin
         k = $urandom_range(99);
         if (k < 45) begin
            clock_ms = ($urandom_range(19) == 0) ? $urandom : clock_ms + $urandom_range(6);
            tick_at(clock_ms);
            done++;
         end else if (k < 80) begin
            md = ($urandom_range(2) == 0) ? MODE_DISCRETE : 3'($urandom);
            send_word(CMD_DEFINE, pick_pic(), $urandom, md, pick_span(), pick_span(),
                      $urandom);
            done++;
            if (md == MODE_DISCRETE) begin
               n = ($urandom_range(11) == 0) ? 34 : $urandom_range(6);
               repeat (n) begin
                  send_word(CMD_APPEND, $urandom, $urandom, $urandom, pick_span(),
                            pick_span(), $urandom);
                  done++;
               end
            end
         end else if (k < 94) begin
            send_word(CMD_APPEND, $urandom, $urandom, $urandom, pick_span(), pick_span(),
                      $urandom);
            done++;
         end else begin
            send_word(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, nothing open, every mode, saturated counts,
      // replacement, an empty discrete set and an ignored command.
      tick_at(0);
      send_word(CMD_APPEND, 16'h1234, 0, 0, 1, 0, 0);
      send_word(CMD_DEFINE, 16'h0000, 6'd0, MODE_FORWARD, 1, 0, 0);
      send_word(CMD_DEFINE, 16'hFFFF, 6'd63, MODE_BACKWARD, 2, 3, 0);
      send_word(CMD_DEFINE, 16'd100, 6'd3, MODE_OSC_UP, 1, 0, 0);
      send_word(CMD_DEFINE, 16'd200, 6'd2, MODE_OSC_DOWN, 0, 2, 0);
      send_word(CMD_DEFINE, 16'd300, 6'd1, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_word(CMD_DEFINE, 16'd500, 6'd5, MODE_DISCRETE, 0, 0, 0);
      send_word(CMD_DEFINE, 16'd400, 6'd9, MODE_DISCRETE, 0, 0, 0);
      send_word(CMD_APPEND, 16'h0000, 0, 0, 32'd0, 32'd0, 0);
      send_word(CMD_APPEND, 16'hFFFF, 6'h3F, 3'h7, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_APPEND, 16'h5A5A, 0, 0, 32'd1, 32'd1, 0);
      send_word(CMD_NONE, 16'hFFFF, 6'h3F, 3'h7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      tick_at(5);
      tick_at(7);
      tick_at(9);
      send_word(CMD_DEFINE, 16'd100, 6'd4, MODE_DISCRETE, 0, 0, 0);
      send_word(CMD_APPEND, 16'd777, 0, 0, 1, 0, 0);
      tick_at(12);
      tick_at(14);
      tick_at(32'hFFFF_FFF0);
      tick_at(32'hFFFF_FFFF);
      clock_ms = 20;

      drain_and_seed(32'd0);
      random_phase(25);
      drain_and_seed(32'hFFFF_FFFF);
      gaps_on = 1'b0;
      random_phase(25);
      gaps_on = 1'b1;
      drain_and_seed($urandom);
      random_phase(25);
      drain_and_seed(32'd1);
      random_phase(25);

      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
